>>> src/dlpd_pkg.sv
// ----------------------------------------------------------------------------
// dlpd_pkg
// Shared widths, register codes, control structs and the drive linearization
// table for the dual lift PD controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dlpd_pkg;

	localparam int ADC_BITS   = 12;
	localparam int ERR_W      = ADC_BITS + 2;   // target - (pot - offset)
	localparam int DELTA_W    = ERR_W + 1;      // err - last_err
	localparam int DD_W       = ERR_W + 2;      // delta after damping (factor < 2)
	localparam int ACC_W      = 32;
	localparam int GAIN_W     = 16;
	localparam int WIN_W      = 12;
	localparam int DAMP_W     = 13;
	localparam int OFS_W      = 8;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int MUL_A_W    = ACC_W;
	localparam int MUL_B_W    = GAIN_W + 1;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int SUM_W      = PROD_W + 2;
	localparam int Q_BITS     = 12;
	localparam int DRV_W      = 8;
	localparam int DRIVE_MAX  = 127;

	localparam int LIN_TABLE_DEPTH = 128;
	localparam int LIN_IDX_W       = $clog2(LIN_TABLE_DEPTH);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN    = 3'd0,
		REG_INTEG_GAIN   = 3'd1,
		REG_DERIV_GAIN   = 3'd2,
		REG_INTEG_WINDOW = 3'd3,
		REG_DERIV_DAMP   = 3'd4,
		REG_LEFT_OFFSET  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [GAIN_W-1:0] prop_gain;
		logic [GAIN_W-1:0] integ_gain;
		logic [GAIN_W-1:0] deriv_gain;
		logic [WIN_W-1:0]  integ_window;
		logic [DAMP_W-1:0] deriv_damp;
		logic [OFS_W-1:0]  left_offset;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		prop_gain:    GAIN_W'(1229),
		integ_gain:   GAIN_W'(0),
		deriv_gain:   GAIN_W'(8192),
		integ_window: WIN_W'(400),
		deriv_damp:   DAMP_W'(1638),
		left_offset:  OFS_W'(15)
	};

	typedef enum logic [1:0] {
		MUL_DAMP = 2'd0,
		MUL_P    = 2'd1,
		MUL_I    = 2'd2,
		MUL_D    = 2'd3
	} mul_sel_t;

	typedef struct packed {
		logic     idle;
		logic     side;       // 0 left, 1 right
		logic     err_step;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sum_first;
		logic     sum_add;
		logic     dfix;
		logic     fin;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic in_valid;
		logic win;
		logic out_free;
	} sts_t;

	localparam logic [LIN_IDX_W-1:0] LIN_TABLE [0:LIN_TABLE_DEPTH-1] = '{
		7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,  7'd0,
		7'd0,  7'd21, 7'd21, 7'd21, 7'd22, 7'd22, 7'd22, 7'd23, 7'd24, 7'd24,
		7'd25, 7'd25, 7'd25, 7'd25, 7'd26, 7'd27, 7'd27, 7'd28, 7'd28, 7'd28,
		7'd28, 7'd29, 7'd30, 7'd30, 7'd30, 7'd31, 7'd31, 7'd32, 7'd32, 7'd32,
		7'd33, 7'd33, 7'd34, 7'd34, 7'd35, 7'd35, 7'd35, 7'd36, 7'd36, 7'd37,
		7'd37, 7'd37, 7'd37, 7'd38, 7'd38, 7'd39, 7'd39, 7'd39, 7'd40, 7'd40,
		7'd41, 7'd41, 7'd42, 7'd42, 7'd43, 7'd44, 7'd44, 7'd45, 7'd45, 7'd46,
		7'd46, 7'd47, 7'd47, 7'd48, 7'd48, 7'd49, 7'd50, 7'd50, 7'd51, 7'd52,
		7'd52, 7'd53, 7'd54, 7'd55, 7'd56, 7'd57, 7'd57, 7'd58, 7'd59, 7'd60,
		7'd61, 7'd62, 7'd63, 7'd64, 7'd65, 7'd66, 7'd67, 7'd67, 7'd68, 7'd70,
		7'd71, 7'd72, 7'd72, 7'd73, 7'd74, 7'd76, 7'd77, 7'd78, 7'd79, 7'd79,
		7'd80, 7'd81, 7'd83, 7'd84, 7'd84, 7'd86, 7'd86, 7'd87, 7'd87, 7'd88,
		7'd88, 7'd89, 7'd89, 7'd90, 7'd90, 7'd127, 7'd127, 7'd127
	};

endpackage

`default_nettype wire

>>> src/dlpd_if.sv
// ----------------------------------------------------------------------------
// dlpd_in_if / dlpd_out_if
// Valid/ready channels carrying one control tick in and one drive pair out.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlpd_in_if;
	import dlpd_pkg::*;

	logic                valid;
	logic                ready;
	logic [ADC_BITS-1:0] target_pos;
	logic [ADC_BITS-1:0] pot_left;
	logic [ADC_BITS-1:0] pot_right;

	modport source (output valid, output target_pos, output pot_left, output pot_right,
		input ready);
	modport sink (input valid, input target_pos, input pot_left, input pot_right,
		output ready);
endinterface

interface dlpd_out_if;
	import dlpd_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [DRV_W-1:0] drive_left;
	logic signed [DRV_W-1:0] drive_right;

	modport source (output valid, output drive_left, output drive_right, input ready);
	modport sink (input valid, input drive_left, input drive_right, output ready);
endinterface

`default_nettype wire

>>> src/dlpd_ctrl.sv
// ----------------------------------------------------------------------------
// dlpd_ctrl
// Sequencer: runs the error, damping (only outside the integral window) and
// three MAC steps per side, left then right, then hands the pair to output reg
// ----------------------------------------------------------------------------
`default_nettype none

module dlpd_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  dlpd_pkg::sts_t sts,
	output dlpd_pkg::cmd_t cmd
);
	import dlpd_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_ERR  = 10'b00_0000_0010,
		ST_DMUL = 10'b00_0000_0100,
		ST_DFIX = 10'b00_0000_1000,
		ST_MP   = 10'b00_0001_0000,
		ST_MI   = 10'b00_0010_0000,
		ST_MD   = 10'b00_0100_0000,
		ST_ADD  = 10'b00_1000_0000,
		ST_FIN  = 10'b01_0000_0000,
		ST_OUT  = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   side_q, side_d;

	always_comb begin
		state_d = state_q;
		side_d  = side_q;
		cmd     = '0;
		cmd.side = side_q;
		cmd.mul_sel = MUL_P;
		case (state_q)
			ST_IDLE: begin
				cmd.idle = 1'b1;
				if (sts.in_valid) begin
					state_d = ST_ERR;
					side_d  = 1'b0;
				end
			end
			ST_ERR: begin
				cmd.err_step = 1'b1;
				state_d = sts.win ? ST_MP : ST_DMUL;
			end
			ST_DMUL: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_DAMP;
				state_d = ST_DFIX;
			end
			ST_DFIX: begin
				cmd.dfix = 1'b1;
				state_d = ST_MP;
			end
			ST_MP: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_P;
				state_d = ST_MI;
			end
			ST_MI: begin
				cmd.sum_first = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = MUL_I;
				state_d = ST_MD;
			end
			ST_MD: begin
				cmd.sum_add = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_D;
				state_d = ST_ADD;
			end
			ST_ADD: begin
				cmd.sum_add = 1'b1;
				state_d = ST_FIN;
			end
			ST_FIN: begin
				cmd.fin = 1'b1;
				if (side_q) begin
					state_d = ST_OUT;
				end else begin
					side_d  = 1'b1;
					state_d = ST_ERR;
				end
			end
			ST_OUT: begin
				cmd.out_load = sts.out_free;
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			side_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			side_q  <= side_d;
		end
	end

	// right side always follows the left one
	a_side_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && !side_q) |=> (state_q == ST_ERR && side_q))
		else $error("right side did not follow left side");

	a_out_after_right: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && side_q) |=> state_q == ST_OUT)
		else $error("output stage skipped");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.err_step |-> !cmd.idle && !cmd.mul_en)
		else $error("error step overlaps other work");

endmodule

`default_nettype wire

>>> src/dlpd_dp.sv
// ----------------------------------------------------------------------------
// dlpd_dp
// Datapath: input capture, per-side error and integrator state, one shared
// 32x17 multiplier with an accumulator, drive scaling, clamp, linearization
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dlpd_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  dlpd_pkg::cfg_t cfg,
	input  dlpd_pkg::cmd_t cmd,
	output dlpd_pkg::sts_t sts,
	dlpd_in_if.sink        in_ch,
	dlpd_out_if.source     out_ch
);
	import dlpd_pkg::*;

	localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(DRIVE_MAX);
	localparam logic signed [SUM_W-1:0] SUM_LO = -SUM_HI;

	logic [ADC_BITS-1:0] target_q, pot_l_q, pot_r_q;

	logic signed [ERR_W-1:0] last_err_q [2];
	logic signed [ACC_W-1:0] accum_q [2];

	logic signed [ERR_W-1:0]  err_q;
	logic signed [DD_W-1:0]   delta_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic signed [DRV_W-1:0]  drv_l_q, drv_r_q;
	logic signed [DRV_W-1:0]  drive_left_q, drive_right_q;
	logic                     out_valid_q;

	logic signed [ERR_W-1:0]   pot_adj, err_now;
	logic [ERR_W-1:0]          err_mag;
	logic                      win_now;
	logic signed [DELTA_W-1:0] delta_now;
	logic signed [ACC_W:0]     acc_ext;
	logic signed [ACC_W-1:0]   acc_sat;

	logic signed [MUL_A_W-1:0] mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PROD_W-1:0]  mul_p;

	logic signed [PROD_W-1:0]  prod_sh, prod_tz;
	logic signed [SUM_W-1:0]   sum_sh, sum_tz;
	logic signed [DRV_W-1:0]   pwr, lut_s, drv_now;
	logic [LIN_IDX_W-1:0]      pmag;

	logic in_xfer;

	assign in_xfer     = in_ch.valid && in_ch.ready;
	assign in_ch.ready = cmd.idle;

	// error, change and integrator update for the selected side
	always_comb begin
		pot_adj = cmd.side ? ERR_W'(pot_r_q)
			: ERR_W'(pot_l_q) - ERR_W'(cfg.left_offset);
		err_now   = ERR_W'(target_q) - pot_adj;
		err_mag   = err_now[ERR_W-1] ? ERR_W'(-err_now) : ERR_W'(err_now);
		win_now   = 32'(err_mag) < 32'(cfg.integ_window);
		delta_now = DELTA_W'(err_now) - DELTA_W'(last_err_q[cmd.side]);
		acc_ext   = (ACC_W+1)'(accum_q[cmd.side]) + (ACC_W+1)'(err_now);
		if (acc_ext[ACC_W] != acc_ext[ACC_W-1]) begin
			acc_sat = acc_ext[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
		end else begin
			acc_sat = acc_ext[ACC_W-1:0];
		end
	end

	// shared multiplier operand select
	always_comb begin
		case (cmd.mul_sel)
			MUL_DAMP: begin
				mul_a = MUL_A_W'(delta_q);
				mul_b = MUL_B_W'(cfg.deriv_damp);
			end
			MUL_P: begin
				mul_a = MUL_A_W'(err_q);
				mul_b = MUL_B_W'(cfg.prop_gain);
			end
			MUL_I: begin
				mul_a = accum_q[cmd.side];
				mul_b = MUL_B_W'(cfg.integ_gain);
			end
			MUL_D: begin
				mul_a = MUL_A_W'(delta_q);
				mul_b = MUL_B_W'(cfg.deriv_gain);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * mul_b;
	end

	// divide by 4096 with truncation toward zero
	always_comb begin
		prod_sh = prod_q >>> Q_BITS;
		prod_tz = prod_sh + PROD_W'(prod_q[PROD_W-1] && (|prod_q[Q_BITS-1:0]));
		sum_sh  = sum_q >>> Q_BITS;
		sum_tz  = sum_sh + SUM_W'(sum_q[SUM_W-1] && (|sum_q[Q_BITS-1:0]));
		if (sum_tz > SUM_HI) begin
			pwr = DRV_W'(DRIVE_MAX);
		end else if (sum_tz < SUM_LO) begin
			pwr = -DRV_W'(DRIVE_MAX);
		end else begin
			pwr = DRV_W'(sum_tz);
		end
		pmag    = pwr[DRV_W-1] ? LIN_IDX_W'(-pwr) : LIN_IDX_W'(pwr);
		lut_s   = DRV_W'(LIN_TABLE[pmag]);
		// right side is negated on output
		drv_now = (pwr[DRV_W-1] ^ cmd.side) ? -lut_s : lut_s;
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			target_q <= in_ch.target_pos;
			pot_l_q  <= in_ch.pot_left;
			pot_r_q  <= in_ch.pot_right;
		end
		if (cmd.err_step) begin
			err_q   <= err_now;
			delta_q <= DD_W'(delta_now);
		end else if (cmd.dfix) begin
			delta_q <= DD_W'(prod_tz);
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.sum_first) begin
			sum_q <= SUM_W'(prod_q);
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + SUM_W'(prod_q);
		end
		if (cmd.fin) begin
			if (cmd.side) begin
				drv_r_q <= drv_now;
			end else begin
				drv_l_q <= drv_now;
			end
		end
		if (cmd.out_load) begin
			drive_left_q  <= drv_l_q;
			drive_right_q <= drv_r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q[0] <= '0;
			last_err_q[1] <= '0;
			accum_q[0]    <= '0;
			accum_q[1]    <= '0;
		end else if (cmd.err_step) begin
			last_err_q[cmd.side] <= err_now;
			accum_q[cmd.side]    <= win_now ? acc_sat : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.drive_left  = drive_left_q;
	assign out_ch.drive_right = drive_right_q;

	assign sts.in_valid = in_ch.valid;
	assign sts.win      = win_now;
	assign sts.out_free = !out_valid_q || out_ch.ready;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ch.ready))
		else $error("output register overwritten before transfer");

	a_accum_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.err_step && !win_now) |=> accum_q[$past(cmd.side)] == '0)
		else $error("integrator not cleared outside window");

	a_drive_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (drive_left_q != 8'sh80 && drive_right_q != 8'sh80))
		else $error("drive outside symmetric range");

endmodule

`default_nettype wire

>>> src/dual_lift_pd_controller_unit.sv
// ----------------------------------------------------------------------------
// dual_lift_pd_controller_unit
// Two-sided lift position controller: PID with integral window per side.
//
// in_ch carries one tick (target_pos, pot_left, pot_right); out_ch returns
// one pair (drive_left, drive_right) for every tick, in order.
// Configuration is a write port (cfg_we, cfg_index, cfg_data), to be written
// by the user only while the block is idle; the block does not enforce this.
// Indexes beyond the register list are ignored. Each side runs the error
// step, then the damping step when the change must be damped (error outside
// the integral window), then the three gain steps: one shared 32x17
// multiplier does the damping product and the three gain products one after
// another. One tick is processed at a time: a new tick is taken only when
// the sequencer is back in idle.
// The output register frees the sequencer: the next tick is accepted while
// a result still waits. If the receiver stalls with a result held, the next
// result waits inside the block and no new tick is taken until it moves.
// Reset clears the error history, the integrators and the output valid, and
// restores the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_lift_pd_controller_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dlpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlpd_pkg::CFG_DATA_W-1:0] cfg_data,
	dlpd_in_if.sink                         in_ch,
	dlpd_out_if.source                      out_ch
);
	import dlpd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_PROP_GAIN:    cfg_q.prop_gain    <= cfg_data[GAIN_W-1:0];
				REG_INTEG_GAIN:   cfg_q.integ_gain   <= cfg_data[GAIN_W-1:0];
				REG_DERIV_GAIN:   cfg_q.deriv_gain   <= cfg_data[GAIN_W-1:0];
				REG_INTEG_WINDOW: cfg_q.integ_window <= cfg_data[WIN_W-1:0];
				REG_DERIV_DAMP:   cfg_q.deriv_damp   <= cfg_data[DAMP_W-1:0];
				REG_LEFT_OFFSET:  cfg_q.left_offset  <= cfg_data[OFS_W-1:0];
				default: begin
				end
			endcase
		end
	end

	dlpd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	dlpd_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.cmd    (cmd),
		.sts    (sts),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire
